### design/lmh_pkg.sv
package lmh_pkg;

    localparam int unsigned HASH_W     = 32;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned NAME_LEN_W = 7;

    localparam logic [HASH_W-1:0] MIX_MUL    = 32'h5bd1e995;
    localparam logic [HASH_W-1:0] SEED_RESET = 32'h31415926;

    localparam int unsigned WORD_SHIFT = 24;
    localparam int unsigned FIN_SHIFT1 = 13;
    localparam int unsigned FIN_SHIFT2 = 15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_ACC,
        ST_TAIL,
        ST_FIN1,
        ST_FIN2
    } ctrl_state_t;

    // Operand select for the shared multiplier
    typedef enum logic [2:0] {
        OP_NONE,
        OP_K1,
        OP_K2,
        OP_ACC,
        OP_TAIL,
        OP_FIN1
    } dp_op_t;

    typedef struct packed {
        logic   load;       // take the presented byte
        dp_op_t op;
        logic   emit_hash;  // finalize into the output register
        logic   emit_zero;  // empty name
    } dp_cmd_t;

    typedef struct packed {
        logic empty;      // presented item is an empty name
        logic word_full;  // presented byte completes a word
        logic last_now;   // presented byte is the last of the name
        logic last;       // stored position has reached the stored length
    } dp_status_t;

    function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

### design/lmh_if.sv
interface lmh_char_if;
    logic                              valid;
    logic                              ready;
    logic [lmh_pkg::CHAR_W-1:0]        char_byte;
    logic [lmh_pkg::NAME_LEN_W-1:0]    name_length;

    modport source (output valid, output char_byte, output name_length, input ready);
    modport sink   (input valid, input char_byte, input name_length, output ready);
endinterface

interface lmh_hash_if;
    logic                          valid;
    logic                          ready;
    logic [lmh_pkg::HASH_W-1:0]    hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

interface lmh_seed_if;
    logic                          valid;
    logic                          ready;
    logic [lmh_pkg::HASH_W-1:0]    hash_seed;

    modport source (output valid, output hash_seed, input ready);
    modport sink   (input valid, input hash_seed, output ready);
endinterface

### design/lmh_ctrl.sv
module lmh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 chars_valid,
    output logic                 chars_ready,
    output logic                 hash_valid,
    input  logic                 hash_ready,
    input  lmh_pkg::dp_status_t  status,
    output lmh_pkg::dp_cmd_t     cmd
);

    lmh_pkg::ctrl_state_t state_reg;
    lmh_pkg::ctrl_state_t state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_free;
    logic                 accept;

    assign out_free    = !out_valid_reg || hash_ready;
    assign chars_ready = (state_reg == lmh_pkg::ST_IDLE) && out_free;
    assign accept      = chars_valid && chars_ready;
    assign hash_valid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lmh_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.op        = lmh_pkg::OP_NONE;
        cmd.emit_hash = 1'b0;
        cmd.emit_zero = 1'b0;

        unique case (state_reg)
            lmh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.empty)
                    begin
                        cmd.emit_zero = 1'b1;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                        if (status.word_full)
                        begin
                            state_next = lmh_pkg::ST_K1;
                        end
                        else if (status.last_now)
                        begin
                            state_next = lmh_pkg::ST_TAIL;
                        end
                    end
                end
            end
            lmh_pkg::ST_K1:
            begin
                cmd.op     = lmh_pkg::OP_K1;
                state_next = lmh_pkg::ST_K2;
            end
            lmh_pkg::ST_K2:
            begin
                cmd.op     = lmh_pkg::OP_K2;
                state_next = lmh_pkg::ST_ACC;
            end
            lmh_pkg::ST_ACC:
            begin
                cmd.op     = lmh_pkg::OP_ACC;
                // full word at the end: no tail to fold
                state_next = status.last ? lmh_pkg::ST_FIN1 : lmh_pkg::ST_IDLE;
            end
            lmh_pkg::ST_TAIL:
            begin
                cmd.op     = lmh_pkg::OP_TAIL;
                state_next = lmh_pkg::ST_FIN1;
            end
            lmh_pkg::ST_FIN1:
            begin
                cmd.op     = lmh_pkg::OP_FIN1;
                state_next = lmh_pkg::ST_FIN2;
            end
            lmh_pkg::ST_FIN2:
            begin
                if (out_free)
                begin
                    cmd.emit_hash = 1'b1;
                    state_next    = lmh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lmh_pkg::ST_IDLE;
            end
        endcase

        if (cmd.emit_hash || cmd.emit_zero)
        begin
            out_valid_next = 1'b1;
        end
        else if (hash_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

### design/lmh_datapath.sv
module lmh_datapath #(
    parameter int MAX_NAME_LENGTH = 127
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [lmh_pkg::CHAR_W-1:0]        char_byte,
    input  logic [lmh_pkg::NAME_LEN_W-1:0]    name_length,
    input  logic                              seed_we,
    input  logic [lmh_pkg::HASH_W-1:0]        seed_data,
    input  lmh_pkg::dp_cmd_t                  cmd,
    output lmh_pkg::dp_status_t               status,
    output logic [lmh_pkg::HASH_W-1:0]        hash_value
);

    localparam int LEN_FIELD_MAX = (1 << lmh_pkg::NAME_LEN_W) - 1;
    localparam int LEN_CAP_I     = (MAX_NAME_LENGTH < LEN_FIELD_MAX) ?
                                   MAX_NAME_LENGTH : LEN_FIELD_MAX;

    logic [lmh_pkg::HASH_W-1:0]      seed_reg;
    logic [lmh_pkg::HASH_W-1:0]      acc_reg;
    logic [lmh_pkg::HASH_W-1:0]      acc_next;
    logic [lmh_pkg::HASH_W-1:0]      word_reg;
    logic [lmh_pkg::HASH_W-1:0]      word_next;
    logic [lmh_pkg::HASH_W-1:0]      hash_reg;
    logic [lmh_pkg::HASH_W-1:0]      hash_next;
    logic [lmh_pkg::NAME_LEN_W-1:0]  pos_reg;
    logic [lmh_pkg::NAME_LEN_W-1:0]  pos_next;
    logic [lmh_pkg::NAME_LEN_W-1:0]  len_reg;
    logic [lmh_pkg::NAME_LEN_W-1:0]  len_next;

    logic                            first;
    logic [lmh_pkg::NAME_LEN_W-1:0]  len_eff;
    logic [lmh_pkg::NAME_LEN_W-1:0]  len_use;
    logic [lmh_pkg::NAME_LEN_W:0]    pos_plus;
    logic [1:0]                      slot;
    logic [lmh_pkg::CHAR_W-1:0]      c_low;
    logic [lmh_pkg::HASH_W-1:0]      c_placed;
    logic [lmh_pkg::HASH_W-1:0]      base_acc;
    logic [lmh_pkg::HASH_W-1:0]      base_word;
    logic [lmh_pkg::HASH_W-1:0]      mul_a;
    logic [lmh_pkg::HASH_W-1:0]      product;

    assign first    = (pos_reg == '0);
    assign len_eff  = (int'(name_length) > LEN_CAP_I) ?
                      LEN_CAP_I[lmh_pkg::NAME_LEN_W-1:0] : name_length;
    assign len_use  = first ? len_eff : len_reg;
    assign pos_plus = {1'b0, pos_reg} + 1'b1;
    assign slot     = pos_reg[1:0];
    assign c_low    = lmh_pkg::fold_lower(char_byte);
    assign c_placed = {{(lmh_pkg::HASH_W-lmh_pkg::CHAR_W){1'b0}}, c_low} << {slot, 3'b000};
    assign base_acc = first ? (seed_reg ^ {{(lmh_pkg::HASH_W-lmh_pkg::NAME_LEN_W){1'b0}},
                                           len_eff})
                            : acc_reg;
    assign base_word = first ? '0 : word_reg;

    assign status.empty     = first && (len_eff == '0);
    assign status.word_full = (slot == 2'd3);
    assign status.last_now  = pos_plus >= {1'b0, len_use};
    assign status.last      = pos_reg >= len_reg;

    // Single shared constant multiplier, result always registered
    always_comb
    begin
        unique case (cmd.op)
            lmh_pkg::OP_K1:   mul_a = word_reg;
            lmh_pkg::OP_K2:   mul_a = word_reg ^ (word_reg >> lmh_pkg::WORD_SHIFT);
            lmh_pkg::OP_ACC:  mul_a = acc_reg;
            lmh_pkg::OP_TAIL: mul_a = acc_reg ^ word_reg;
            lmh_pkg::OP_FIN1: mul_a = acc_reg ^ (acc_reg >> lmh_pkg::FIN_SHIFT1);
            default:          mul_a = word_reg;
        endcase
    end

    assign product = mul_a * lmh_pkg::MIX_MUL;

    always_comb
    begin
        acc_next  = acc_reg;
        word_next = word_reg;
        pos_next  = pos_reg;
        len_next  = len_reg;
        hash_next = hash_reg;

        if (cmd.load)
        begin
            acc_next  = base_acc;
            word_next = base_word | c_placed;
            pos_next  = pos_plus[lmh_pkg::NAME_LEN_W-1:0];
            len_next  = len_use;
        end

        unique case (cmd.op)
            lmh_pkg::OP_K1:   word_next = product;
            lmh_pkg::OP_K2:   word_next = product;
            lmh_pkg::OP_ACC:
            begin
                acc_next  = product ^ word_reg;
                word_next = '0;
            end
            lmh_pkg::OP_TAIL: acc_next = product;
            lmh_pkg::OP_FIN1: acc_next = product;
            default:
            begin
            end
        endcase

        if (cmd.emit_hash)
        begin
            hash_next = acc_reg ^ (acc_reg >> lmh_pkg::FIN_SHIFT2);
            pos_next  = '0;
            len_next  = '0;
        end
        else if (cmd.emit_zero)
        begin
            hash_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= lmh_pkg::SEED_RESET;
            pos_reg  <= '0;
            len_reg  <= '0;
        end
        else
        begin
            if (seed_we)
            begin
                seed_reg <= seed_data;
            end
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        word_reg <= word_next;
        hash_reg <= hash_next;
    end

    assign hash_value = hash_reg;

endmodule

### design/lowercase_murmur2_string_hash.sv
// Channel  | Dir | Payload                          | Transaction
// ---------+-----+----------------------------------+--------------------------------
// chars    | in  | char_byte[7:0], name_length[6:0] | one name byte (length on first)
// hash     | out | hash_value[31:0]                 | one hash per name
// cfg      | in  | hash_seed[31:0]                  | seed write, never stalls
//
// Steps: a byte that does not complete a 4-byte word is only accepted. A byte that
// completes a word is accepted, then makes three passes through the one 32x32
// constant multiplier. The end of a name adds tail fold, finalize multiply and
// output load after a tail; finalize multiply and output load on a full word.
// An empty name loads 0 into the output register at its accept edge.
// Reset: rst_n async active low; seed returns to 0x31415926, no name in progress.
// Stalls: no bytes are taken during multiplier passes; a hash waiting in the output
// register blocks new bytes and the output load until the receiver takes it.

// Lower-case folding MurmurHash2 (32 bit) over a name streamed one byte per
// transaction. Controller sequences the shared multiplier; datapath holds the
// running hash, the partial word and the byte count.
module lowercase_murmur2_string_hash #(
    parameter int MAX_NAME_LENGTH = 127
) (
    input logic       clk,
    input logic       rst_n,
    lmh_char_if.sink  chars,
    lmh_hash_if.source hash,
    lmh_seed_if.sink  cfg
);

    lmh_pkg::dp_cmd_t    cmd;
    lmh_pkg::dp_status_t status;

    // Seed register takes every write; the user must write only while idle, the block does not enforce it.
    assign cfg.ready = 1'b1;

    lmh_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars_valid (chars.valid),
        .chars_ready (chars.ready),
        .hash_valid  (hash.valid),
        .hash_ready  (hash.ready),
        .status      (status),
        .cmd         (cmd)
    );

    lmh_datapath #(
        .MAX_NAME_LENGTH (MAX_NAME_LENGTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_byte   (chars.char_byte),
        .name_length (chars.name_length),
        .seed_we     (cfg.valid),
        .seed_data   (cfg.hash_seed),
        .cmd         (cmd),
        .status      (status),
        .hash_value  (hash.hash_value)
    );

endmodule

### design/lmh_checker.sv
module lmh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        chars_valid,
    input logic        chars_ready,
    input logic        hash_valid,
    input logic        hash_ready,
    input logic [31:0] hash_value,
    input logic        cfg_ready
);

    // Held result stays put until taken
    a_hash_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hash_valid && !hash_ready |=> hash_valid && $stable(hash_value))
        else $error("hash dropped or changed while stalled");

    // A full, stalled output register blocks new bytes
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        hash_valid && !hash_ready |-> !chars_ready)
        else $error("byte accepted while output stalled");

    // A new hash appears only after an empty-name transaction or a busy stretch
    a_hash_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hash_valid) |-> $past(chars_valid && chars_ready) || $past(!chars_ready))
        else $error("hash appeared from nowhere");

    // Seed port never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("seed port stalled");

endmodule

bind lowercase_murmur2_string_hash lmh_checker u_lmh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .chars_valid (chars.valid),
    .chars_ready (chars.ready),
    .hash_valid  (hash.valid),
    .hash_ready  (hash.ready),
    .hash_value  (hash.hash_value),
    .cfg_ready   (cfg.ready)
);
